/* rtl/core/fbe_pkg.sv */
// Shared types, constants and helpers for the feedback echo block.
// No dependencies; every other file of the block uses this package.
package fbe_pkg;

   localparam int DelayDepth = 65536;
   localparam int AddrW      = $clog2(DelayDepth);
   localparam int FillW      = AddrW + 1;
   localparam int SampleW    = 24;
   localparam int DelayW     = 16;
   localparam int CoefW      = 17;
   localparam int StateW     = 32;
   localparam int MulAW      = StateW + 1;
   localparam int ProdW      = MulAW + CoefW + 1;
   localparam int GainShift  = 8;
   localparam int CoefShift  = 16;
   localparam int EchoShift  = 8;
   localparam int TapW       = (AddrW > DelayW) ? AddrW : DelayW;
   localparam int CsrIdxW    = 8;

   localparam logic [CoefW-1:0]  CoefOne       = CoefW'(65536);
   localparam logic [DelayW-1:0] DelayRstVal   = DelayW'(22050);
   localparam logic [CoefW-1:0]  GainRstVal    = CoefW'(41943);
   localparam logic [CoefW-1:0]  LpCoefRstVal  = CoefW'(35666);
   localparam logic [CoefW-1:0]  HpCoefRstVal  = CoefW'(0);

   localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
   localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DELAY   = CsrIdxW'(0),
      CSR_GAIN    = CsrIdxW'(1),
      CSR_LP_COEF = CsrIdxW'(2),
      CSR_HP_COEF = CsrIdxW'(3)
   } csr_idx_type;

   typedef struct packed {
      logic [DelayW-1:0] delay;
      logic [CoefW-1:0]  gain;
      logic [CoefW-1:0]  lp_coef;
      logic [CoefW-1:0]  hp_coef;
   } cfg_type;

   typedef struct packed {
      logic                      wr_en;
      logic [AddrW-1:0]          wr_addr;
      logic signed [SampleW-1:0] wr_data;
      logic                      rd_en;
      logic [AddrW-1:0]          rd_addr;
   } mem_req_type;

   // Limit a coefficient to 1.0.
   function automatic logic [CoefW-1:0] clamp_coef(input logic [CoefW-1:0] v);
      return (v > CoefOne) ? CoefOne : v;
   endfunction

   // Saturate a value one bit wider than a sample to the sample range.
   function automatic logic signed [SampleW-1:0] sat_sample(
      input logic signed [SampleW:0] v);
      logic signed [SampleW:0] hi;
      logic signed [SampleW:0] lo;
      hi = (SampleW+1)'(SampleMax);
      lo = (SampleW+1)'(SampleMin);
      if (v > hi) begin
         return SampleMax;
      end else if (v < lo) begin
         return SampleMin;
      end
      return v[SampleW-1:0];
   endfunction

endpackage

/* rtl/core/fbe_delay_ram.sv */
// Circular delay memory: one write port, one read port, registered read data.
// Depends on fbe_pkg for the address width and the request struct.
module fbe_delay_ram (
   input  logic                              clock,
   input  fbe_pkg::mem_req_type              mem_req,
   output logic signed [fbe_pkg::SampleW-1:0] rd_data
);
   import fbe_pkg::*;

   logic signed [SampleW-1:0] mem [DelayDepth];
   logic signed [SampleW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fbe_csr.sv */
// Configuration registers: delay, feedback gain and the two filter coefficients.
// Depends on fbe_pkg for register indexes, reset values and coefficient clamping.
module fbe_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [fbe_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fbe_pkg::CoefW-1:0]    csr_wdata,
   output fbe_pkg::cfg_type             cfg
);
   import fbe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DELAY:   cfg_in.delay   = csr_wdata[DelayW-1:0];
            CSR_GAIN:    cfg_in.gain    = clamp_coef(csr_wdata);
            CSR_LP_COEF: cfg_in.lp_coef = clamp_coef(csr_wdata);
            CSR_HP_COEF: cfg_in.hp_coef = clamp_coef(csr_wdata);
            default:     cfg_in = cfg_ff;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay   <= DelayRstVal;
         cfg_ff.gain    <= GainRstVal;
         cfg_ff.lp_coef <= LpCoefRstVal;
         cfg_ff.hp_coef <= HpCoefRstVal;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

/* rtl/core/fbe_datapath.sv */
// Sequencer and arithmetic: tap read, gain, low-pass, high-pass, write-back.
// Depends on fbe_pkg; drives the delay memory through a request struct.
module fbe_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  fbe_pkg::cfg_type                   cfg,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [fbe_pkg::SampleW-1:0] req_sample_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fbe_pkg::SampleW-1:0] rsp_echo_out,
   output fbe_pkg::mem_req_type               mem_req,
   input  logic signed [fbe_pkg::SampleW-1:0] rd_data
);
   import fbe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_SUB_LP,
      ST_MUL_LP,
      ST_ADD_LP,
      ST_MUL_HP,
      ST_ADD_HP,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [AddrW-1:0]          wp_ff, wp_in;
   logic [FillW-1:0]          fill_ff, fill_in;
   logic                      tap_valid_ff, tap_valid_in;
   logic signed [SampleW-1:0] dry_ff, dry_in;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   logic signed [MulAW-1:0]   diff_ff, diff_in;
   logic signed [StateW-1:0]  lp_ff, lp_in;
   logic signed [StateW-1:0]  hp_ff, hp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SampleW-1:0] echo_ff, echo_in;

   logic                      accept;
   logic                      out_free;
   logic [AddrW-1:0]          wp_next;
   logic [TapW-1:0]           tap_full;
   logic [AddrW-1:0]          tap;
   logic signed [SampleW-1:0] delayed;
   logic signed [MulAW-1:0]   mul_a;
   logic signed [CoefW:0]     mul_b;
   logic signed [ProdW-1:0]   mul_p;
   logic signed [StateW-1:0]  x_val;
   logic signed [MulAW-1:0]   step;
   logic signed [MulAW-1:0]   sum;
   logic signed [SampleW:0]   echo_wide;
   logic signed [SampleW-1:0] echo_val;
   logic signed [SampleW:0]   store_wide;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wp_next  = wp_ff + AddrW'(1);
   assign tap_full = TapW'(wp_next) - TapW'(cfg.delay);
   assign tap      = tap_full[AddrW-1:0];
   assign delayed  = tap_valid_ff ? rd_data : '0;

   // Shared multiplier: delayed sample by gain, then the two filter steps.
   always_comb begin
      if (state_ff == ST_MUL_X) begin
         mul_a = MulAW'(delayed);
         mul_b = {1'b0, cfg.gain};
      end else if (state_ff == ST_MUL_LP) begin
         mul_a = diff_ff;
         mul_b = {1'b0, cfg.lp_coef};
      end else begin
         mul_a = diff_ff;
         mul_b = {1'b0, cfg.hp_coef};
      end
   end

   assign mul_p      = ProdW'(mul_a) * ProdW'(mul_b);
   assign x_val      = $signed(prod_ff[GainShift+StateW-1:GainShift]);
   assign step       = $signed(prod_ff[CoefShift+MulAW-1:CoefShift]);
   assign echo_wide  = $signed(diff_ff[MulAW-1:EchoShift]);
   assign echo_val   = sat_sample(echo_wide);
   assign store_wide = (SampleW+1)'(echo_val) + (SampleW+1)'(dry_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      tap_valid_in = tap_valid_ff;
      dry_in       = dry_ff;
      prod_in      = prod_ff;
      diff_in      = diff_ff;
      lp_in        = lp_ff;
      hp_in        = hp_ff;
      echo_in      = echo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sum          = '0;

      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = tap;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = wp_ff;
      mem_req.wr_data = sat_sample(store_wide);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wp_in         = wp_next;
               dry_in        = req_sample_in;
               mem_req.rd_en = 1'b1;
               // An entry never written since reset reads as zero.
               if (tap != '0) begin
                  tap_valid_in = (fill_ff >= FillW'(tap));
               end else begin
                  tap_valid_in = (fill_ff == FillW'(DelayDepth));
               end
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            prod_in  = mul_p;
            state_in = ST_SUB_LP;
         end
         ST_SUB_LP: begin
            diff_in  = MulAW'(x_val) - MulAW'(lp_ff);
            state_in = ST_MUL_LP;
         end
         ST_MUL_LP: begin
            prod_in  = mul_p;
            state_in = ST_ADD_LP;
         end
         ST_ADD_LP: begin
            sum      = MulAW'(lp_ff) + step;
            lp_in    = sum[StateW-1:0];
            diff_in  = MulAW'(lp_in) - MulAW'(hp_ff);
            state_in = ST_MUL_HP;
         end
         ST_MUL_HP: begin
            prod_in  = mul_p;
            state_in = ST_ADD_HP;
         end
         ST_ADD_HP: begin
            sum      = MulAW'(hp_ff) + step;
            hp_in    = sum[StateW-1:0];
            diff_in  = MulAW'(lp_ff) - MulAW'(hp_in);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the output register can take the item.
            if (out_free) begin
               mem_req.wr_en = 1'b1;
               echo_in       = echo_val;
               rsp_valid_in  = 1'b1;
               if (fill_ff != FillW'(DelayDepth)) begin
                  fill_in = fill_ff + FillW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         lp_ff        <= '0;
         hp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         lp_ff        <= lp_in;
         hp_ff        <= hp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tap_valid_ff <= tap_valid_in;
      dry_ff       <= dry_in;
      prod_ff      <= prod_in;
      diff_ff      <= diff_in;
      echo_ff      <= echo_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_echo_out = echo_ff;

endmodule

/* rtl/core/feedback_echo_with_damping_top.sv */
// Top level of the feedback echo with low-pass and high-pass damping.
// Depends on fbe_pkg, fbe_csr, fbe_datapath and fbe_delay_ram.
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | req_sample_in, 24 bit signed
//   rsp_    | out       | rsp_valid / rsp_stall  | rsp_echo_out, 24 bit signed
//   csr_    | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// Each item runs through these steps in order: the tap read, then three passes
// through the shared multiplier, each followed by an add or subtract step,
// and the write-back; a new item is accepted only after its write-back.
// No clearing pass after reset: a fill count marks which entries hold data.
// req_stall is high while an item is in work; the finished item waits in the
// output register and the block stalls at write-back only if that is full.
module feedback_echo_with_damping_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [fbe_pkg::SampleW-1:0] req_sample_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fbe_pkg::SampleW-1:0] rsp_echo_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fbe_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [fbe_pkg::CoefW-1:0]          csr_wdata
);
   import fbe_pkg::*;

   cfg_type                   cfg;
   mem_req_type               mem_req;
   logic signed [SampleW-1:0] rd_data;

   fbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fbe_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_echo_out  (rsp_echo_out),
      .mem_req       (mem_req),
      .rd_data       (rd_data)
   );

   fbe_delay_ram u_delay_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

/* rtl/core/fbe_checker.sv */
// Port-level checks on the echo block's top level, attached by bind.
// Depends on fbe_pkg for the port widths.
module fbe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic signed [fbe_pkg::SampleW-1:0] req_sample_in,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [fbe_pkg::SampleW-1:0] rsp_echo_out,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [fbe_pkg::CsrIdxW-1:0]        csr_index,
   input logic [fbe_pkg::CoefW-1:0]          csr_wdata
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_echo_out))
      else $error("result changed while stalled");

   // One item at a time: stall right after an accepted item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepted item");

   // No result can appear the cycle after an item enters.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Finishing an item always leaves a result on the output.
   a_result_on_release: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("item finished without a result");

endmodule

bind feedback_echo_with_damping_top fbe_checker u_fbe_checker (.*);
